### design/cut_edge_boundary_node_indexer_unit_assert.svh
// Assertion macros shared by the design files of the boundary node indexer.
// Each macro samples on the rising edge of clock and is off during reset.
`ifndef CUT_EDGE_BOUNDARY_NODE_INDEXER_UNIT_ASSERT_SVH
`define CUT_EDGE_BOUNDARY_NODE_INDEXER_UNIT_ASSERT_SVH

// Property that must hold in the same cycle.
`define CEBNI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define CEBNI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/cebni_pkg.sv
package cebni_pkg;

   // Field widths of the edge and result words.
   localparam int NODE_W = 20;
   localparam int PART_W = 8;
   localparam int CNT_W  = 21;

   // Saturation limits of the counters and of the local index.
   localparam logic [CNT_W-1:0]  CNT_MAX   = 21'h1FFFFF;
   localparam logic [NODE_W-1:0] LOCAL_MAX = 20'hFFFFF;

   // The mark store keeps one row of 32 mark bits per address.
   localparam int ROW_BITS   = 32;
   localparam int ROW_BIT_AW = 5;

   // Result queue geometry.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_AW    = 3;
   localparam int RSP_CW    = 4;

   // One edge.
   typedef struct packed {
      logic [NODE_W-1:0] src_node;
      logic [PART_W-1:0] src_part;
      logic [NODE_W-1:0] dst_node;
      logic [PART_W-1:0] dst_part;
   } req_word_type;

   // One newly found boundary node.
   typedef struct packed {
      logic [NODE_W-1:0] node_id;
      logic [PART_W-1:0] part_id;
      logic [NODE_W-1:0] local_index;
      logic [CNT_W-1:0]  total_found;
      logic              last;
   } rsp_word_type;

endpackage

### design/cebni_mark_store.sv
module cebni_mark_store #(
   parameter int ROWS   = 32768,
   parameter int ROW_AW = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ROW_AW-1:0]               rd_row,
   output logic [cebni_pkg::ROW_BITS-1:0]  rd_data,
   input  logic                            wr_en,
   input  logic [ROW_AW-1:0]               wr_row,
   input  logic [cebni_pkg::ROW_BITS-1:0]  wr_data,
   output logic                            clearing
);

   logic [cebni_pkg::ROW_BITS-1:0] mem [ROWS];
   logic [cebni_pkg::ROW_BITS-1:0] rd_data_ff;
   logic                           clearing_ff;
   logic                           clearing_in;
   logic [ROW_AW-1:0]              clr_ptr_ff;
   logic [ROW_AW-1:0]              clr_ptr_in;
   logic                           mem_we;
   logic [ROW_AW-1:0]              mem_wa;
   logic [cebni_pkg::ROW_BITS-1:0] mem_wd;

   // Clearing pass: one row per cycle after reset.
   always_comb begin
      clearing_in = clearing_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clearing_ff) begin
         clr_ptr_in = clr_ptr_ff + ROW_AW'(1);
         if (clr_ptr_ff == ROW_AW'(ROWS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ptr_ff  <= clr_ptr_in;
      end
   end

   // The clearing pass owns the write port until it is done.
   assign mem_we = clearing_ff || wr_en;
   assign mem_wa = clearing_ff ? clr_ptr_ff : wr_row;
   assign mem_wd = clearing_ff ? '0 : wr_data;

   // Synchronous memory; a read in the cycle of a write to the same row returns the old row.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_row];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

### design/cebni_count_store.sv
module cebni_count_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [AW-1:0]                rd_addr,
   output logic [cebni_pkg::CNT_W-1:0]  rd_data,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [cebni_pkg::CNT_W-1:0]  wr_data
);

   logic [cebni_pkg::CNT_W-1:0] mem [DEPTH];
   logic [cebni_pkg::CNT_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]            vld_ff;
   logic                        rd_vld_ff;

   // Per-entry valid bits stand in for a cleared counter array.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // Counter memory with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // A counter never written reads as zero.
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

### design/cebni_rsp_fifo.sv
module cebni_rsp_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_a_en,
   input  cebni_pkg::rsp_word_type          wr_a_word,
   input  logic                             wr_b_en,
   input  cebni_pkg::rsp_word_type          wr_b_word,
   output logic [cebni_pkg::RSP_CW-1:0]     count,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cebni_pkg::rsp_word_type          rsp_word
);

   cebni_pkg::rsp_word_type          entry_ff [cebni_pkg::RSP_DEPTH];
   logic [cebni_pkg::RSP_AW-1:0]     wr_ptr_ff;
   logic [cebni_pkg::RSP_AW-1:0]     wr_ptr_in;
   logic [cebni_pkg::RSP_AW-1:0]     rd_ptr_ff;
   logic [cebni_pkg::RSP_AW-1:0]     rd_ptr_in;
   logic [cebni_pkg::RSP_CW-1:0]     count_ff;
   logic [cebni_pkg::RSP_CW-1:0]     count_in;
   logic                             pop;
   logic [cebni_pkg::RSP_AW-1:0]     wr_ptr_next;

   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + cebni_pkg::RSP_AW'(1);

   // Pointer and fill count update; up to two words enter per cycle.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + cebni_pkg::RSP_AW'(wr_a_en) + cebni_pkg::RSP_AW'(wr_b_en);
      rd_ptr_in = rd_ptr_ff + cebni_pkg::RSP_AW'(pop);
      count_in  = count_ff + cebni_pkg::RSP_CW'(wr_a_en) + cebni_pkg::RSP_CW'(wr_b_en)
                  - cebni_pkg::RSP_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word A goes first, word B into the following slot.
   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         entry_ff[wr_ptr_ff] <= wr_a_word;
      end
      if (wr_b_en) begin
         entry_ff[wr_ptr_next] <= wr_b_word;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### design/cut_edge_boundary_node_indexer_unit.sv
// Boundary node indexer. Each accepted edge word yields zero, one or two
// result words: an endpoint of a cut edge (partitions differ) that is not yet
// marked is marked, takes the next local index of its partition and is
// reported with the running total; the source comes first and the final word
// of an edge has last set. An edge is taken only in the source phase, since
// each endpoint needs its own read-modify-write of the mark memory and the
// partition counter memory, each with one read port. Results leave through an
// eight-word queue, so the input keeps flowing while results wait, as long as
// room for them is reserved. After reset the mark memory is cleared one 32-bit
// row per cycle, all ceil(min(NODE_COUNT, 2^20) / 32) rows (32768 at the
// default), and no edge is taken until that pass ends.
module cut_edge_boundary_node_indexer_unit #(
   parameter int NODE_COUNT = 1048576,
   parameter int PART_COUNT = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cebni_pkg::req_word_type  req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cebni_pkg::rsp_word_type  rsp_word
);

   `include "cut_edge_boundary_node_indexer_unit_assert.svh"

   localparam int MARK_DEPTH = (NODE_COUNT < 2**cebni_pkg::NODE_W) ?
                               NODE_COUNT : 2**cebni_pkg::NODE_W;
   localparam int MARK_ROWS  = (MARK_DEPTH + cebni_pkg::ROW_BITS - 1) / cebni_pkg::ROW_BITS;
   localparam int ROW_AW     = (MARK_ROWS > 1) ? $clog2(MARK_ROWS) : 1;
   localparam int PART_DEPTH = (PART_COUNT < 2**cebni_pkg::PART_W) ?
                               PART_COUNT : 2**cebni_pkg::PART_W;
   localparam int PART_AW    = $clog2(PART_DEPTH);
   localparam int CR_W       = cebni_pkg::RSP_CW + 1;

   // Issue phase codes.
   localparam logic PH_SRC = 1'b0;
   localparam logic PH_DST = 1'b1;

   logic                              phase_ff;
   logic                              phase_in;
   logic [cebni_pkg::NODE_W-1:0]      hold_node_ff;
   logic [cebni_pkg::PART_W-1:0]      hold_part_ff;
   logic                              hold_en_ff;

   logic                              b_valid_ff;
   logic                              b_is_dst_ff;
   logic [cebni_pkg::NODE_W-1:0]      b_node_ff;
   logic [cebni_pkg::PART_W-1:0]      b_part_ff;
   logic                              b_en_ff;

   logic                              fw_valid_ff;
   logic [ROW_AW-1:0]                 fw_row_ff;
   logic [cebni_pkg::ROW_BITS-1:0]    fw_data_ff;
   logic                              cfw_valid_ff;
   logic [PART_AW-1:0]                cfw_part_ff;
   logic [cebni_pkg::CNT_W-1:0]       cfw_data_ff;

   logic [cebni_pkg::CNT_W-1:0]       total_ff;
   logic [cebni_pkg::CNT_W-1:0]       total_in;
   logic                              pend_valid_ff;
   logic                              pend_valid_in;
   cebni_pkg::rsp_word_type           pend_word_ff;

   logic                              clearing;
   logic [cebni_pkg::RSP_CW-1:0]      rsp_count;
   logic                              src_issue;
   logic                              dst_issue;
   logic                              credit_ok;
   logic                              cut;
   logic                              src_en;
   logic                              dst_en;
   logic [cebni_pkg::NODE_W-1:0]      iss_node;
   logic [cebni_pkg::PART_W-1:0]      iss_part;

   logic [cebni_pkg::ROW_BITS-1:0]    mark_rd_data;
   logic [cebni_pkg::ROW_BITS-1:0]    row_cur;
   logic [ROW_AW-1:0]                 b_row;
   logic [cebni_pkg::ROW_BIT_AW-1:0]  b_bit;
   logic [PART_AW-1:0]                b_pidx;
   logic [cebni_pkg::CNT_W-1:0]       cnt_rd_data;
   logic [cebni_pkg::CNT_W-1:0]       cnt_cur;
   logic [cebni_pkg::CNT_W-1:0]       cnt_next;
   logic                              hit;
   logic                              mark_wr_en;
   logic [cebni_pkg::ROW_BITS-1:0]    mark_wr_data;
   cebni_pkg::rsp_word_type           hit_word;
   logic                              wr_a_en;
   logic                              wr_b_en;
   cebni_pkg::rsp_word_type           wr_a_word;

   // Reserve room for the results of this edge and of the one in flight.
   assign credit_ok = (CR_W'(rsp_count) + (b_valid_ff ? CR_W'(2) : CR_W'(0)) + CR_W'(2))
                      <= CR_W'(cebni_pkg::RSP_DEPTH);

   assign req_ready = !clearing && (phase_ff == PH_SRC) && credit_ok;
   assign src_issue = req_valid && req_ready;
   assign dst_issue = (phase_ff == PH_DST);

   // Endpoint qualification: cut edge, node and partition in range.
   assign cut    = (req_word.src_part != req_word.dst_part);
   assign src_en = cut && (32'(req_word.src_node) < NODE_COUNT)
                       && (32'(req_word.src_part) < PART_COUNT);
   assign dst_en = cut && (32'(req_word.dst_node) < NODE_COUNT)
                       && (32'(req_word.dst_part) < PART_COUNT);

   // The source reads in the accept cycle, the destination in the next one.
   assign iss_node = dst_issue ? hold_node_ff : req_word.src_node;
   assign iss_part = dst_issue ? hold_part_ff : req_word.src_part;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SRC: begin
            if (src_issue) begin
               phase_in = PH_DST;
            end
         end
         PH_DST: begin
            phase_in = PH_SRC;
         end
         default: begin
            phase_in = PH_SRC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SRC;
         b_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         b_valid_ff <= src_issue || dst_issue;
      end
   end

   // Destination hold and lookup stage payload.
   always_ff @(posedge clock) begin
      if (src_issue) begin
         hold_node_ff <= req_word.dst_node;
         hold_part_ff <= req_word.dst_part;
         hold_en_ff   <= dst_en;
      end
      b_is_dst_ff <= dst_issue;
      b_node_ff   <= iss_node;
      b_part_ff   <= iss_part;
      b_en_ff     <= dst_issue ? hold_en_ff : src_en;
   end

   cebni_mark_store #(
      .ROWS   (MARK_ROWS),
      .ROW_AW (ROW_AW)
   ) u_mark (
      .clock    (clock),
      .reset    (reset),
      .rd_row   (iss_node[ROW_AW+cebni_pkg::ROW_BIT_AW-1:cebni_pkg::ROW_BIT_AW]),
      .rd_data  (mark_rd_data),
      .wr_en    (mark_wr_en),
      .wr_row   (b_row),
      .wr_data  (mark_wr_data),
      .clearing (clearing)
   );

   cebni_count_store #(
      .DEPTH (PART_DEPTH),
      .AW    (PART_AW)
   ) u_count (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (iss_part[PART_AW-1:0]),
      .rd_data (cnt_rd_data),
      .wr_en   (mark_wr_en),
      .wr_addr (b_pidx),
      .wr_data (cnt_next)
   );

   // Lookup stage: forward the previous cycle's writes over the stale reads.
   assign b_row   = b_node_ff[ROW_AW+cebni_pkg::ROW_BIT_AW-1:cebni_pkg::ROW_BIT_AW];
   assign b_bit   = b_node_ff[cebni_pkg::ROW_BIT_AW-1:0];
   assign b_pidx  = b_part_ff[PART_AW-1:0];
   assign row_cur = (fw_valid_ff && (fw_row_ff == b_row)) ? fw_data_ff : mark_rd_data;
   assign cnt_cur = (cfw_valid_ff && (cfw_part_ff == b_pidx)) ? cfw_data_ff : cnt_rd_data;

   assign hit          = b_valid_ff && b_en_ff && !row_cur[b_bit];
   assign mark_wr_en   = hit;
   assign mark_wr_data = row_cur | (cebni_pkg::ROW_BITS'(1) << b_bit);
   assign cnt_next     = (cnt_cur == cebni_pkg::CNT_MAX) ? cnt_cur
                                                         : cnt_cur + cebni_pkg::CNT_W'(1);
   assign total_in     = (hit && (total_ff != cebni_pkg::CNT_MAX))
                         ? total_ff + cebni_pkg::CNT_W'(1) : total_ff;

   // Result word of a newly marked endpoint.
   always_comb begin
      hit_word.node_id     = b_node_ff;
      hit_word.part_id     = b_part_ff;
      hit_word.local_index = (cnt_cur > cebni_pkg::CNT_W'(cebni_pkg::LOCAL_MAX))
                             ? cebni_pkg::LOCAL_MAX : cnt_cur[cebni_pkg::NODE_W-1:0];
      hit_word.total_found = total_in;
      hit_word.last        = 1'b1;
   end

   // A source result waits for the destination to settle its last flag.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      wr_a_en       = 1'b0;
      wr_b_en       = 1'b0;
      wr_a_word     = hit_word;
      if (b_valid_ff && !b_is_dst_ff) begin
         pend_valid_in = hit;
      end else if (b_valid_ff && b_is_dst_ff) begin
         pend_valid_in = 1'b0;
         wr_a_en       = pend_valid_ff || hit;
         wr_b_en       = pend_valid_ff && hit;
         if (pend_valid_ff) begin
            wr_a_word      = pend_word_ff;
            wr_a_word.last = !hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_valid_ff   <= 1'b0;
         cfw_valid_ff  <= 1'b0;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         fw_valid_ff   <= hit;
         cfw_valid_ff  <= hit;
         total_ff      <= total_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fw_row_ff   <= b_row;
      fw_data_ff  <= mark_wr_data;
      cfw_part_ff <= b_pidx;
      cfw_data_ff <= cnt_next;
      if (b_valid_ff && !b_is_dst_ff) begin
         pend_word_ff <= hit_word;
      end
   end

   cebni_rsp_fifo u_rsp (
      .clock     (clock),
      .reset     (reset),
      .wr_a_en   (wr_a_en),
      .wr_a_word (wr_a_word),
      .wr_b_en   (wr_b_en),
      .wr_b_word (hit_word),
      .count     (rsp_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // A destination lookup always directly follows its source lookup.
   `CEBNI_ASSERT(a_dst_after_src, (b_valid_ff && b_is_dst_ff) |-> $past(b_valid_ff && !b_is_dst_ff), "destination lookup without source lookup")
   // The held source result is gone once the destination is resolved.
   `CEBNI_ASSERT_NEXT(a_pend_drained, b_valid_ff && b_is_dst_ff, !pend_valid_ff, "source result left pending")
   // The reservation keeps the result queue from overfilling.
   `CEBNI_ASSERT(a_queue_bound, 1'b1 |-> (rsp_count <= cebni_pkg::RSP_CW'(cebni_pkg::RSP_DEPTH)), "result queue overflow")
   // No mark update races the clearing pass.
   `CEBNI_ASSERT(a_no_mark_in_clear, mark_wr_en |-> !clearing, "mark write during clearing pass")

endmodule

### tb/cut_edge_boundary_node_indexer_unit_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the boundary node indexer, predicts the boundary
// nodes that every accepted edge word uncovers and compares each accepted
// result word with the oldest prediction.
module cut_edge_boundary_node_indexer_unit_checker #(
   parameter int NODE_COUNT = 1048576,
   parameter int PART_COUNT = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  cebni_pkg::req_word_type  req_word,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  cebni_pkg::rsp_word_type  rsp_word,
   output int                       error_count,
   output int                       due_count
);
   import cebni_pkg::*;

   // Shadow copy of the mark store and the counters.
   bit               node_marked [NODE_COUNT];
   logic [CNT_W-1:0] part_tally [PART_COUNT];
   logic [CNT_W-1:0] found_tally;

   // Boundary node words that the block still owes, oldest first.
   rsp_word_type boundary_due [$];

   initial begin
      for (int p = 0; p < PART_COUNT; p++) begin
         part_tally[p] = '0;
      end
      found_tally = '0;
   end

   // Marks one endpoint if it qualifies and builds its result word.
   task automatic claim_node(input logic [NODE_W-1:0] node,
                             input logic [PART_W-1:0] part,
                             output bit hit, output rsp_word_type w);
      logic [CNT_W-1:0] slot;
      hit = 1'b0;
      w   = '0;
      if (int'(node) >= NODE_COUNT || int'(part) >= PART_COUNT) begin
         return;
      end
      if (node_marked[node]) begin
         return;
      end
      node_marked[node] = 1'b1;
      slot = part_tally[part];
      if (part_tally[part] < CNT_MAX) begin
         part_tally[part] = part_tally[part] + 1'b1;
      end
      if (found_tally < CNT_MAX) begin
         found_tally = found_tally + 1'b1;
      end
      w.node_id     = node;
      w.part_id     = part;
      w.local_index = (slot > {1'b0, LOCAL_MAX}) ? LOCAL_MAX : slot[NODE_W-1:0];
      w.total_found = found_tally;
      w.last        = 1'b0;
      hit = 1'b1;
   endtask

   // Works out the words one edge causes: source first, then destination.
   task automatic find_boundary_nodes(input req_word_type e);
      bit           src_hit;
      bit           dst_hit;
      rsp_word_type src_w;
      rsp_word_type dst_w;
      if (e.src_part == e.dst_part) begin
         return;
      end
      claim_node(e.src_node, e.src_part, src_hit, src_w);
      claim_node(e.dst_node, e.dst_part, dst_hit, dst_w);
      if (dst_hit) begin
         dst_w.last = 1'b1;
      end else if (src_hit) begin
         src_w.last = 1'b1;
      end
      if (src_hit) begin
         boundary_due.push_back(src_w);
      end
      if (dst_hit) begin
         boundary_due.push_back(dst_w);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Result words are checked before the edge of the same cycle is
   // predicted, since a word can never come from an edge taken that cycle.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (boundary_due.size() == 0) begin
               $error("result word with nothing due: node_id 0x%0h", rsp_word.node_id);
               error_count++;
            end else begin
               want = boundary_due.pop_front();
               compare_field("node_id", 32'(want.node_id), 32'(rsp_word.node_id));
               compare_field("part_id", 32'(want.part_id), 32'(rsp_word.part_id));
               compare_field("local_index", 32'(want.local_index),
                             32'(rsp_word.local_index));
               compare_field("total_found", 32'(want.total_found),
                             32'(rsp_word.total_found));
               compare_field("last", 32'(want.last), 32'(rsp_word.last));
            end
         end
         if (req_valid && req_ready) begin
            find_boundary_nodes(req_word);
         end
         due_count = boundary_due.size();
      end
   end

endmodule

### tb/tb_cut_edge_boundary_node_indexer_unit.sv
`timescale 1ns / 100ps

// Drives edge words into the boundary node indexer and gives the verdict;
// prediction and comparison live in the checker beside the block.
module tb_cut_edge_boundary_node_indexer_unit;
   import cebni_pkg::*;

   localparam int NODE_COUNT  = 1048576;
   localparam int PART_COUNT  = 256;
   localparam int EDGE_COUNT  = 1250;
   localparam int CYCLE_LIMIT = 250000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 30;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   int error_count;
   int due_count;
   int cycle_count;

   // Idling controls shared between the sender and the receiver.
   bit send_idle_on;
   bit recv_idle_on;
   bit hold_wanted;
   bit hold_taken;
   int hold_left;

   // Recently used nodes, so that later edges hit already marked nodes.
   logic [NODE_W-1:0] node_pool [$];

   cut_edge_boundary_node_indexer_unit #(
      .NODE_COUNT (NODE_COUNT),
      .PART_COUNT (PART_COUNT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   cut_edge_boundary_node_indexer_unit_checker #(
      .NODE_COUNT (NODE_COUNT),
      .PART_COUNT (PART_COUNT)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .error_count (error_count),
      .due_count   (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run guard: covers the clearing pass after reset many times over.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_cut_edge_boundary_node_indexer_unit NOT OK");
            $finish;
         end
      end
   end

   // Receiver: random idling, plus one long hold-off counted here.
   initial begin
      rsp_ready  = 1'b0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(recv_idle_on && $urandom_range(0, 99) < 18);
         end
      end
   end

   // Offers one edge word and waits until it is taken.
   task automatic send_edge(input logic [NODE_W-1:0] sn, input logic [PART_W-1:0] sp,
                            input logic [NODE_W-1:0] dn, input logic [PART_W-1:0] dp);
      req_word_type w;
      w.src_node = sn;
      w.src_part = sp;
      w.dst_node = dn;
      w.dst_part = dp;
      @(negedge clock);
      while (send_idle_on && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      node_pool.push_back(sn);
      node_pool.push_back(dn);
      while (node_pool.size() > 64) begin
         void'(node_pool.pop_front());
      end
   endtask

   // Mostly fresh nodes, often repeats, now and then the range ends.
   function automatic logic [NODE_W-1:0] pick_node();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35 && node_pool.size() > 0) begin
         return node_pool[$urandom_range(0, node_pool.size() - 1)];
      end else if (roll < 40) begin
         return ($urandom_range(0, 1) == 1) ? LOCAL_MAX : '0;
      end
      return NODE_W'($urandom());
   endfunction

   // Few partitions most of the time, so local indexes climb.
   function automatic logic [PART_W-1:0] pick_part();
      if ($urandom_range(0, 99) < 70) begin
         return PART_W'($urandom_range(0, 7));
      end
      return PART_W'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [NODE_W-1:0] sn;
      logic [NODE_W-1:0] dn;
      logic [PART_W-1:0] sp;
      logic [PART_W-1:0] dp;
      int                roll;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      hold_wanted  = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed edges: range ends, marked endpoints, shared partition and
      // an edge whose two endpoints are the same node.
      send_edge(20'h00000, 8'd0, 20'hFFFFF, 8'd255);
      send_edge(20'h00000, 8'd1, 20'hFFFFF, 8'd0);
      send_edge(20'h00005, 8'd3, 20'h00005, 8'd3);
      send_edge(20'h00006, 8'd2, 20'h00007, 8'd2);
      send_edge(20'h00008, 8'd4, 20'h00008, 8'd9);
      send_edge(20'h00000, 8'd0, 20'h00009, 8'd1);
      send_edge(20'h0000A, 8'd1, 20'h00000, 8'd4);
      send_edge(20'hAAAAA, 8'hAA, 20'h55555, 8'h55);
      send_edge(20'h55555, 8'h55, 20'hAAAAA, 8'hAA);
      send_edge(20'h0000B, 8'd255, 20'h0000C, 8'd254);
      send_edge(20'hFFFFE, 8'd128, 20'h00001, 8'd127);
      send_edge(20'h0000D, 8'd0, 20'h0000D, 8'd255);
      send_edge(20'h0000E, 8'd255, 20'h0000F, 8'd255);
      send_edge(20'h7FFFF, 8'h7F, 20'h80000, 8'h80);

      // Random edges; a quiet stretch without idling and one long hold-off.
      for (int i = 0; i < EDGE_COUNT; i++) begin
         send_idle_on = !(i >= 300 && i < 550);
         recv_idle_on = !(i >= 300 && i < 550);
         if (i == 700) begin
            hold_wanted = 1'b1;
         end
         sn   = pick_node();
         dn   = pick_node();
         sp   = pick_part();
         dp   = pick_part();
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            dp = sp;
         end else if (roll < 13) begin
            dn = sn;
         end
         send_edge(sn, sp, dn, dp);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray word.
      while (due_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && due_count == 0) begin
         $display("tb_cut_edge_boundary_node_indexer_unit OK");
      end else begin
         $display("tb_cut_edge_boundary_node_indexer_unit NOT OK");
      end
      $finish;
   end

endmodule
